### hdl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the nearest pick search block.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int RAD_W         = 40;
    localparam int ROOT_W        = RAD_W / 2;
    localparam int STEP_W        = $clog2(ROOT_W);
    localparam int DIV5_SHIFT    = 22;
    localparam logic [ROOT_W-1:0] DIV5_MUL = 20'hCCCCD;

    localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(TABLE_ENTRIES);

    localparam logic CFG_ZOOM = 1'b0;
    localparam logic CFG_VPH  = 1'b1;

    localparam logic [15:0] ZOOM_RESET = 16'd256;
    localparam logic [12:0] VPH_RESET  = 13'd1024;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        RES_OK   = 2'd0,
        RES_MISS = 2'd1,
        RES_FULL = 2'd2,
        RES_HIT  = 2'd3
    } res_kind_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [9:0]         depth;
        logic [15:0]        reach;
        logic [31:0]        wx;
        logic [31:0]        wy;
        logic [31:0]        wz;
        logic [31:0]        id;
        logic [7:0]         layer;
        logic [7:0]         obj_type;
    } entry_t;

    typedef struct packed {
        logic      capture;
        logic      clear;
        logic      add_write;
        logic      scan_clear;
        logic      idx_inc;
        logic      rd_en;
        logic      rd_best;
        logic      take_best;
        logic      sqrt_start;
        logic      thr_load;
        logic      res_load;
        res_kind_t res_kind;
        logic      depth_mode;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  full;
        logic  count_zero;
        logic  idx_last;
        logic  better;
        logic  sqrt_done;
        logic  best_valid;
        logic  best_type_one;
        logic  out_free;
    } sts_t;

endpackage

`default_nettype wire

### hdl/nps_isqrt.sv
// ----------------------------------------------------------------------------
// nps_isqrt
// Iterative integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_isqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [nps_pkg::RAD_W-1:0]  radicand,
    output logic                            done,
    output logic [nps_pkg::ROOT_W-1:0]      root
);
    import nps_pkg::*;

    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [ROOT_W+3:0]   rem_sh;
    logic [ROOT_W+3:0]   trial;
    logic                ge;
    logic [ROOT_W+1:0]   rem_next;
    logic [ROOT_W-1:0]   root_next;

    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (ROOT_W+2)'(rem_sh - trial) : (ROOT_W+2)'(rem_sh);
        root_next = {root_reg[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

### hdl/nps_datapath.sv
// ----------------------------------------------------------------------------
// nps_datapath
// Entry table, config registers, distance pipeline, best tracking, result.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire nps_pkg::cmd_t       cmd,
    output nps_pkg::sts_t            sts,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic [1:0]          func,
    input  wire logic signed [15:0]  pos_x,
    input  wire logic signed [15:0]  pos_y,
    input  wire logic [9:0]          depth,
    input  wire logic [31:0]         world_x,
    input  wire logic [31:0]         world_y,
    input  wire logic [31:0]         world_z,
    input  wire logic [7:0]          pick_size,
    input  wire logic [31:0]         obj_id,
    input  wire logic [7:0]          layer,
    input  wire logic [7:0]          obj_type,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               status,
    output logic [31:0]              hit_world_x,
    output logic [31:0]              hit_world_y,
    output logic [31:0]              hit_world_z,
    output logic [31:0]              hit_id,
    output logic [7:0]               hit_layer,
    output logic [7:0]               hit_type
);
    import nps_pkg::*;

    logic [15:0]        zoom_reg;
    logic [12:0]        vph_reg;

    func_t              func_reg;
    entry_t             cap_reg;
    logic [7:0]         pick_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               best_valid_reg;

    entry_t             mem [TABLE_ENTRIES];
    entry_t             rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             new_entry;

    logic [23:0]        reach_prod;
    logic [26:0]        reach_x5;
    logic [18:0]        reach_full;

    logic signed [17:0] qy;
    logic signed [16:0] dxs;
    logic signed [18:0] dys;
    logic [18:0]        dy_abs;

    logic [16:0]        dx_reg;
    logic [16:0]        dy_reg;
    logic [9:0]         z1_reg;
    logic               inr1_reg;
    logic [33:0]        sqx_reg;
    logic [33:0]        sqy_reg;
    logic [19:0]        sqz_reg;
    logic               inr2_reg;
    logic [RAD_W-1:0]   metric_reg;
    logic               inr3_reg;

    logic [34:0]        sum_s;
    logic [RAD_W-1:0]   sum_t;

    logic               sqrt_done;
    logic [ROOT_W-1:0]  root;
    logic [2*ROOT_W-1:0] prod_reg;
    logic [ROOT_W-1:0]  q5;
    logic [ROOT_W-1:0]  m_reg;
    logic [RAD_W-1:0]   thr_reg;

    logic               out_valid_reg;
    logic [1:0]         status_reg;
    entry_t             res_reg;

    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg <= ZOOM_RESET;
            vph_reg  <= VPH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ZOOM: zoom_reg <= cfg_data;
                CFG_VPH:  vph_reg  <= cfg_data[12:0];
                default:  zoom_reg <= zoom_reg;
            endcase
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg          <= func_t'(func);
            cap_reg.x         <= pos_x;
            cap_reg.y         <= pos_y;
            cap_reg.depth     <= depth;
            cap_reg.reach     <= '0;
            cap_reg.wx        <= world_x;
            cap_reg.wy        <= world_y;
            cap_reg.wz        <= world_z;
            cap_reg.id        <= obj_id;
            cap_reg.layer     <= layer;
            cap_reg.obj_type  <= obj_type;
            pick_reg          <= pick_size;
        end
    end

    // reach, rounded half up and saturated
    always_comb
    begin
        reach_prod = pick_reg * zoom_reg;
        reach_x5   = {reach_prod, 2'b00} + 27'(reach_prod);
        reach_full = 19'((reach_x5 + 27'd128) >> 8);
        new_entry  = cap_reg;
        new_entry.reach = (reach_full[18:16] != 3'b000) ? 16'hFFFF : reach_full[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            idx_reg        <= '0;
            best_idx_reg   <= '0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
                count_reg <= '0;
            else if (cmd.add_write)
                count_reg <= count_reg + 1'b1;

            if (cmd.scan_clear)
            begin
                idx_reg        <= '0;
                best_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.idx_inc)
                    idx_reg <= idx_reg + 1'b1;
                if (cmd.take_best)
                begin
                    best_idx_reg   <= idx_reg;
                    best_valid_reg <= 1'b1;
                end
            end
        end
    end

    // entry table
    assign rd_addr = cmd.rd_best ? best_idx_reg : idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.add_write)
            mem[count_reg[IDX_W-1:0]] <= new_entry;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // distance pipeline
    always_comb
    begin
        qy     = $signed({5'b00000, vph_reg}) - $signed({{2{cap_reg.y[15]}}, cap_reg.y})
                 - 18'sd1;
        dxs    = $signed({rd_data_reg.x[15], rd_data_reg.x})
                 - $signed({cap_reg.x[15], cap_reg.x});
        dys    = $signed({{3{rd_data_reg.y[15]}}, rd_data_reg.y}) - $signed({qy[17], qy});
        dy_abs = dys[18] ? 19'(-dys) : 19'(dys);
        sum_s  = 35'(sqx_reg) + 35'(sqy_reg);
        sum_t  = RAD_W'({sum_s, 4'b0000}) + RAD_W'({sum_s, 3'b000}) + RAD_W'(sum_s)
                 + RAD_W'(sqz_reg);
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dxs[16] ? 17'(-dxs) : 17'(dxs);
        dy_reg     <= dy_abs[16:0];
        z1_reg     <= rd_data_reg.depth;
        inr1_reg   <= ((dxs[16] ? 17'(-dxs) : 17'(dxs)) <= {1'b0, rd_data_reg.reach})
                      && (dy_abs <= {3'b000, rd_data_reg.reach});
        sqx_reg    <= dx_reg * dx_reg;
        sqy_reg    <= dy_reg * dy_reg;
        sqz_reg    <= z1_reg * z1_reg;
        inr2_reg   <= inr1_reg;
        metric_reg <= cmd.depth_mode ? sum_t : RAD_W'(sum_s);
        inr3_reg   <= inr2_reg;
    end

    // floor root of the new best, turned into a squared threshold
    nps_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (metric_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    always_comb
    begin
        q5 = ROOT_W'(prod_reg >> DIV5_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= root * DIV5_MUL;
        m_reg    <= cmd.depth_mode ? ROOT_W'({q5, 2'b00} + 22'(q5)) : root;
        if (cmd.thr_load)
            thr_reg <= m_reg * m_reg;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.res_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            case (cmd.res_kind)
                RES_HIT:
                begin
                    status_reg <= STATUS_OK;
                    res_reg    <= rd_data_reg;
                end
                RES_MISS:
                begin
                    status_reg <= STATUS_MISS;
                    res_reg    <= '0;
                end
                RES_FULL:
                begin
                    status_reg <= STATUS_FULL;
                    res_reg    <= '0;
                end
                default:
                begin
                    status_reg <= STATUS_OK;
                    res_reg    <= '0;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign hit_world_x = res_reg.wx;
    assign hit_world_y = res_reg.wy;
    assign hit_world_z = res_reg.wz;
    assign hit_id      = res_reg.id;
    assign hit_layer   = res_reg.layer;
    assign hit_type    = res_reg.obj_type;

    always_comb
    begin
        sts.func          = func_reg;
        sts.full          = (count_reg == TABLE_FULL);
        sts.count_zero    = (count_reg == '0);
        sts.idx_last      = ({1'b0, idx_reg} == CNT_W'(count_reg - 1'b1));
        sts.better        = inr3_reg && (!best_valid_reg || (metric_reg < thr_reg));
        sts.sqrt_done     = sqrt_done;
        sts.best_valid    = best_valid_reg;
        sts.best_type_one = (rd_data_reg.obj_type == 8'd1);
        sts.out_free      = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

### hdl/nps_ctrl.sv
// ----------------------------------------------------------------------------
// nps_ctrl
// Sequencer for clear, add and the one or two query scans.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire nps_pkg::sts_t  sts,
    output nps_pkg::cmd_t       cmd
);
    import nps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_E1,
        S_E2,
        S_E3,
        S_CMP,
        S_SQRT,
        S_DIV,
        S_MSEL,
        S_SQR,
        S_ADV,
        S_BEST_RD,
        S_BEST_CHK,
        S_DONE
    } state_t;

    state_t    state_reg;
    state_t    state_next;
    logic      pass_reg;
    logic      pass_next;
    res_kind_t kind_reg;
    res_kind_t kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
            kind_reg  <= RES_OK;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        kind_next      = kind_reg;
        cmd            = '0;
        cmd.res_kind   = kind_reg;
        cmd.depth_mode = pass_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                kind_next  = RES_OK;
                state_next = S_DONE;
                case (sts.func)
                    FUNC_CLEAR: cmd.clear = 1'b1;
                    FUNC_ADD:
                    begin
                        if (sts.full)
                            kind_next = RES_FULL;
                        else
                            cmd.add_write = 1'b1;
                    end
                    FUNC_QUERY:
                    begin
                        if (sts.count_zero)
                            kind_next = RES_MISS;
                        else
                        begin
                            cmd.scan_clear = 1'b1;
                            pass_next      = 1'b0;
                            state_next     = S_SCAN_RD;
                        end
                    end
                    default: kind_next = RES_OK;
                endcase
            end
            S_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_E1;
            end
            S_E1: state_next = S_E2;
            S_E2: state_next = S_E3;
            S_E3: state_next = S_CMP;
            S_CMP:
            begin
                if (sts.better)
                begin
                    cmd.take_best  = 1'b1;
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT;
                end
                else
                    state_next = S_ADV;
            end
            S_SQRT:
            begin
                if (sts.sqrt_done)
                    state_next = S_DIV;
            end
            S_DIV:  state_next = S_MSEL;
            S_MSEL: state_next = S_SQR;
            S_SQR:
            begin
                cmd.thr_load = 1'b1;
                state_next   = S_ADV;
            end
            S_ADV:
            begin
                if (sts.idx_last)
                begin
                    if (sts.best_valid)
                        state_next = S_BEST_RD;
                    else
                    begin
                        kind_next  = RES_MISS;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_BEST_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_best = 1'b1;
                state_next  = S_BEST_CHK;
            end
            S_BEST_CHK:
            begin
                if (!pass_reg && sts.best_type_one)
                begin
                    pass_next      = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN_RD;
                end
                else
                begin
                    kind_next  = RES_HIT;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### hdl/nearest_pick_search.sv
// clear, add and func 3 items go from decode straight to the done state
// a query passes each stored entry through read, E1 to E3, compare and advance;
// a closer entry adds the iterative square root (one root bit per cycle)
// a winner of type 1 repeats the scan with depth, so a query is up to two scans
// one item at a time; reset empties the table and loads zoom 256, height 1024
// ----------------------------------------------------------------------------
// nearest_pick_search
// Pick table for screen objects: clear, add entry and nearest click query.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_pick_search (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          func,
    input  wire logic signed [15:0]  pos_x,
    input  wire logic signed [15:0]  pos_y,
    input  wire logic [9:0]          depth,
    input  wire logic [31:0]         world_x,
    input  wire logic [31:0]         world_y,
    input  wire logic [31:0]         world_z,
    input  wire logic [7:0]          pick_size,
    input  wire logic [31:0]         obj_id,
    input  wire logic [7:0]          layer,
    input  wire logic [7:0]          obj_type,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               status,
    output logic [31:0]              hit_world_x,
    output logic [31:0]              hit_world_y,
    output logic [31:0]              hit_world_z,
    output logic [31:0]              hit_id,
    output logic [7:0]               hit_layer,
    output logic [7:0]               hit_type
);
    import nps_pkg::*;

    cmd_t cmd;
    sts_t sts;

    nps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nps_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .depth       (depth),
        .world_x     (world_x),
        .world_y     (world_y),
        .world_z     (world_z),
        .pick_size   (pick_size),
        .obj_id      (obj_id),
        .layer       (layer),
        .obj_type    (obj_type),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .hit_world_x (hit_world_x),
        .hit_world_y (hit_world_y),
        .hit_world_z (hit_world_z),
        .hit_id      (hit_id),
        .hit_layer   (hit_layer),
        .hit_type    (hit_type)
    );

endmodule

`default_nettype wire

### hdl/nps_checker.sv
// ----------------------------------------------------------------------------
// nps_checker
// Port level checks for the nearest pick search block.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_ready,
    input  wire logic         out_valid,
    input  wire logic         out_ready,
    input  wire logic [1:0]   status,
    input  wire logic [31:0]  hit_world_x,
    input  wire logic [31:0]  hit_id
);
    import nps_pkg::*;

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous item in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(hit_id))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_MISS
                       || status == STATUS_FULL))
        else $error("unknown status code");

    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> hit_id == '0 && hit_world_x == '0)
        else $error("hit fields set without a hit");

endmodule

bind nearest_pick_search nps_checker u_nps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .hit_world_x (hit_world_x),
    .hit_id      (hit_id)
);

`default_nettype wire
